@@ rtl/bitplane_vram_port_with_multiwrite_unit_assert.svh @@
// Assertion macros for the bit-plane video memory port.
`ifndef BITPLANE_VRAM_PORT_WITH_MULTIWRITE_UNIT_ASSERT_SVH
`define BITPLANE_VRAM_PORT_WITH_MULTIWRITE_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while in reset.
`define BVP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while in reset.
`define BVP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

// Delayed implication, sampled on clk_i, off while in reset.
`define BVP_ASSERT_LAT3(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> ##3 (cons)) \
    else $error(msg);

`endif

@@ rtl/bvp_pkg.sv @@
package bvp_pkg;

  localparam int unsigned DEF_PLANE_BYTES = 16384;
  localparam int unsigned DEF_CRTC_COUNT  = 18;
  localparam int unsigned DEF_BANK_COUNT  = 2;

  localparam logic [1:0] KIND_WRITE  = 2'd0;
  localparam logic [1:0] KIND_READ   = 2'd1;
  localparam logic [1:0] KIND_SIGNAL = 2'd2;

  localparam logic [1:0]  REGION_IO       = 2'd0;
  localparam logic [15:0] ADDR_BANK_SEL   = 16'h1fd0;
  localparam logic [15:0] CRTC_PORT_MASK  = 16'hff0f;
  localparam logic [15:0] CRTC_INDEX_PORT = 16'h1800;
  localparam logic [15:0] CRTC_DATA_PORT  = 16'h1801;

  localparam int unsigned CRTC_R_VTOTAL = 4;
  localparam int unsigned CRTC_R_VADJ   = 5;
  localparam int unsigned CRTC_R_RASTER = 9;
  localparam logic [12:0] HIRES_LINES   = 13'd400;

  localparam int unsigned BIT_BANK   = 4;
  localparam int unsigned BIT_LEVEL  = 5;
  localparam int unsigned BIT_COLUMN = 6;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] bus_address;
    logic [7:0]  bus_data;
  } req_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       vram_hit;
    logic       multi_mode;
    logic       hires_flag;
    logic       wide_columns;
  } rsp_t;

  typedef struct packed {
    logic clear;
    logic latch;
    logic exec;
    logic calc;
  } dp_cmd_t;

  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_EXEC  = 5'b00100,
    ST_CALC  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

endpackage

@@ rtl/bvp_ram.sv @@
module bvp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/bvp_ctrl.sv @@
module bvp_ctrl import bvp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o,
  output logic       busy_o,
  output logic       valid_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
        if (status_i.clear_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_CALC;
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_DONE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o  = (state_q != ST_IDLE);
  assign valid_o = (state_q == ST_DONE);

endmodule

@@ rtl/bvp_dp.sv @@
module bvp_dp import bvp_pkg::*; #(
  parameter int unsigned PLANE_BYTES = DEF_PLANE_BYTES,
  parameter int unsigned CRTC_COUNT  = DEF_CRTC_COUNT,
  parameter int unsigned BANK_COUNT  = DEF_BANK_COUNT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  dp_cmd_t    cmd_i,
  input  req_t       req_i,
  output dp_status_t status_o,
  output rsp_t       rsp_o
);

  localparam int unsigned DEPTH = BANK_COUNT * PLANE_BYTES;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned OW    = $clog2(PLANE_BYTES);

  function automatic logic [OW-1:0] plane_ofs(input logic [13:0] v);
    logic [19:0] r;
    r = {6'd0, v};
    for (int k = 4; k >= 0; k--) begin
      if (r >= (20'(PLANE_BYTES) << k)) begin
        r = r - (20'(PLANE_BYTES) << k);
      end
    end
    return r[OW-1:0];
  endfunction

  req_t          item_q;
  logic [OW-1:0] ofs_q;
  logic [7:0]    rdata_q;
  logic [AW-1:0] clr_q;

  logic       hit_q, hit_d;
  logic       multi_q, multi_d;
  logic       level_q, level_d;
  logic       bank_q, bank_d;
  logic [7:0] cidx_q, cidx_d;
  logic [7:0] crtc_q [CRTC_COUNT];
  logic       crtc_we;
  logic       upd_q, upd_d;
  logic       hires_q;
  logic       col_q, col_d;

  logic [1:0]    region;
  logic [1:0]    plane;
  logic [AW-1:0] plane_addr;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [2:0]    ram_we;
  logic [7:0]    ram_rdata [3];

  logic [7:0]  vt_p1;
  logic [5:0]  ras_p1;
  logic [12:0] vtotal;

  assign region     = item_q.bus_address[15:14];
  assign plane      = region - 2'd1;
  assign plane_addr = AW'(ofs_q) +
                      (((BANK_COUNT > 1) && bank_q) ? AW'(PLANE_BYTES) : AW'(0));

  assign status_o.clear_last = (clr_q == AW'(DEPTH - 1));

  always_comb begin
    hit_d   = hit_q;
    multi_d = multi_q;
    level_d = level_q;
    bank_d  = bank_q;
    cidx_d  = cidx_q;
    upd_d   = upd_q;
    col_d   = col_q;
    crtc_we = 1'b0;
    ram_we  = 3'b000;
    if (cmd_i.latch) begin
      hit_d = 1'b0;
      upd_d = 1'b0;
    end
    if (cmd_i.exec) begin
      case (item_q.kind)
        KIND_WRITE: begin
          if (region == REGION_IO) begin
            if (multi_q) begin
              ram_we = 3'b111;
              hit_d  = 1'b1;
            end else if (item_q.bus_address == ADDR_BANK_SEL) begin
              bank_d = item_q.bus_data[BIT_BANK];
            end else if ((item_q.bus_address & CRTC_PORT_MASK) == CRTC_INDEX_PORT) begin
              cidx_d = item_q.bus_data;
            end else if ((item_q.bus_address & CRTC_PORT_MASK) == CRTC_DATA_PORT) begin
              if (cidx_q < 8'(CRTC_COUNT)) begin
                crtc_we = 1'b1;
                upd_d   = 1'b1;
              end
            end
          end else begin
            for (int q = 0; q < 3; q++) begin
              ram_we[q] = multi_q ? (plane != 2'(q)) : (plane == 2'(q));
            end
            hit_d = 1'b1;
          end
        end
        KIND_READ: begin
          multi_d = 1'b0;
          hit_d   = (region != REGION_IO);
        end
        KIND_SIGNAL: begin
          if (level_q && !item_q.bus_data[BIT_LEVEL]) begin
            multi_d = 1'b1;
          end
          level_d = item_q.bus_data[BIT_LEVEL];
          col_d   = item_q.bus_data[BIT_COLUMN];
        end
        default: begin
        end
      endcase
    end
    if (cmd_i.clear) begin
      ram_we = 3'b111;
    end
  end

  assign ram_addr  = cmd_i.clear ? clr_q : plane_addr;
  assign ram_wdata = cmd_i.clear ? 8'd0 : item_q.bus_data;

  for (genvar g = 0; g < 3; g++) begin : g_plane
    bvp_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we[g]),
      .addr_i  (ram_addr),
      .wdata_i (ram_wdata),
      .rdata_o (ram_rdata[g])
    );
  end

  assign vt_p1  = {1'b0, crtc_q[CRTC_R_VTOTAL][6:0]} + 8'd1;
  assign ras_p1 = {1'b0, crtc_q[CRTC_R_RASTER][4:0]} + 6'd1;
  assign vtotal = 13'(vt_p1 * ras_p1) + 13'(crtc_q[CRTC_R_VADJ][4:0]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q   <= '0;
      hit_q   <= 1'b0;
      multi_q <= 1'b0;
      level_q <= 1'b0;
      bank_q  <= 1'b0;
      cidx_q  <= 8'd0;
      upd_q   <= 1'b0;
      hires_q <= 1'b1;
      col_q   <= 1'b1;
      for (int i = 0; i < CRTC_COUNT; i++) begin
        crtc_q[i] <= 8'd0;
      end
    end else begin
      if (cmd_i.clear) begin
        clr_q <= clr_q + AW'(1);
      end
      hit_q   <= hit_d;
      multi_q <= multi_d;
      level_q <= level_d;
      bank_q  <= bank_d;
      cidx_q  <= cidx_d;
      upd_q   <= upd_d;
      col_q   <= col_d;
      for (int i = 0; i < CRTC_COUNT; i++) begin
        if (crtc_we && (cidx_q == 8'(i))) begin
          crtc_q[i] <= item_q.bus_data;
        end
      end
      if (cmd_i.calc && upd_q) begin
        hires_q <= (vtotal > HIRES_LINES);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      item_q <= req_i;
      ofs_q  <= plane_ofs(req_i.bus_address[13:0]);
    end
    if (cmd_i.calc) begin
      rdata_q <= ((item_q.kind == KIND_READ) && (region != REGION_IO)) ?
                 ram_rdata[plane] : 8'd0;
    end
  end

  assign rsp_o.read_data    = rdata_q;
  assign rsp_o.vram_hit     = hit_q;
  assign rsp_o.multi_mode   = multi_q;
  assign rsp_o.hires_flag   = hires_q;
  assign rsp_o.wide_columns = col_q;

endmodule

@@ rtl/bitplane_vram_port_with_multiwrite_unit.sv @@
// Channel   Direction  Handshake                      Payload
// request   in         start high, busy low           req_i (req_t)
// response  out        valid_o, one cycle, no stall   rsp_o (rsp_t)
//
// Each word passes four steps, and a new word is taken only once the last is strobed: latch,
// execute on the plane RAMs, collect the registered RAM read and the CRTC line total, strobe.
// The result is strobed in the done state, after the execute and calculate states.
// After reset a clearing pass writes zero to every address of all planes with busy
// high; busy also stays high until each result is strobed.
// The receiver cannot stall: valid_o marks the result for exactly one cycle.
module bitplane_vram_port_with_multiwrite_unit import bvp_pkg::*; #(
  parameter int unsigned PLANE_BYTES = DEF_PLANE_BYTES,
  parameter int unsigned CRTC_COUNT  = DEF_CRTC_COUNT,
  parameter int unsigned BANK_COUNT  = DEF_BANK_COUNT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  output logic busy,
  input  req_t req_i,
  output logic valid_o,
  output rsp_t rsp_o
);

  dp_cmd_t    cmd;
  dp_status_t status;

  bvp_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .valid_o  (valid_o)
  );

  bvp_dp #(
    .PLANE_BYTES (PLANE_BYTES),
    .CRTC_COUNT  (CRTC_COUNT),
    .BANK_COUNT  (BANK_COUNT)
  ) u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .req_i    (req_i),
    .status_o (status),
    .rsp_o    (rsp_o)
  );

endmodule

@@ rtl/bvp_checker.sv @@
`include "bitplane_vram_port_with_multiwrite_unit_assert.svh"

module bvp_checker import bvp_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input req_t req_i,
  input logic valid_o,
  input rsp_t rsp_o
);

  `BVP_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accept did not raise busy")
  `BVP_ASSERT_NOW(a_nohit_zero, valid_o && !rsp_o.vram_hit, rsp_o.read_data == 8'd0, "read data without hit")
  `BVP_ASSERT_LAT3(a_read_clears, start && !busy && (req_i.kind == KIND_READ), valid_o && !rsp_o.multi_mode, "read left multi mode set")
  `BVP_ASSERT_LAT3(a_signal_nohit, start && !busy && (req_i.kind == KIND_SIGNAL), valid_o && !rsp_o.vram_hit, "signal word reported a hit")

endmodule

bind bitplane_vram_port_with_multiwrite_unit bvp_checker u_bvp_checker (.*);
